// File: src/rtch_pkg.sv
package rtch_pkg;

	// Datapath widths
	typedef logic signed [16:0] opa_t;   // vertex differences, direction
	typedef logic signed [34:0] opb_t;   // edges, p and q cross products
	typedef logic signed [51:0] prod_t;  // one product
	typedef logic signed [55:0] acc_t;   // dot products
	typedef logic [55:0]        mag_t;   // divider remainder and divisor
	typedef logic [23:0]        quo_t;   // quotient and dividend feed bits
	typedef logic [4:0]         step_t;  // divider step count

	// Config register indexes
	localparam logic [1:0] CFG_TRI_COUNT = 2'd0;
	localparam logic [1:0] CFG_DET_MIN   = 2'd1;

	localparam logic [1:0] NUM_CORNERS = 2'd3;
	localparam logic [4:0] NUM_UOPS    = 5'd24;
	localparam quo_t       T_SAT       = 24'hFFFFFF;
	localparam step_t      T_STEPS     = 5'd24;
	localparam step_t      UV_STEPS    = 5'd17;

	// Multiplier operand selects
	typedef enum logic [3:0] {
		A_DX, A_DY, A_DZ, A_E1X, A_E1Y, A_E1Z, A_E2X, A_E2Y, A_E2Z, A_SX, A_SY, A_SZ
	} asel_t;

	typedef enum logic [3:0] {
		B_E1X, B_E1Y, B_E1Z, B_E2X, B_E2Y, B_E2Z, B_PX, B_PY, B_PZ, B_QX, B_QY, B_QZ
	} bsel_t;

	// Accumulator destinations
	typedef enum logic [3:0] {
		D_PX, D_PY, D_PZ, D_QX, D_QY, D_QZ, D_DET, D_UN, D_VN, D_TN
	} dest_t;

	typedef struct packed {
		logic  sub;
		logic  first;
		logic  last;
		dest_t dest;
	} mac_ctl_t;

	typedef struct packed {
		logic  wr;
		dest_t dest;
		acc_t  value;
	} mac_res_t;

	typedef struct packed {
		asel_t    a;
		bsel_t    b;
		mac_ctl_t ctl;
	} uop_t;

	typedef struct packed {
		logic  start;
		mag_t  rem;
		quo_t  feed;
		step_t steps;
		mag_t  den;
	} div_req_t;

	// Multiply-accumulate program for one triangle
	function automatic uop_t uop_rom(input logic [4:0] idx);
		uop_t u;
		unique case (idx)
			5'd0:  u = '{A_DY,  B_E2Z, '{1'b0, 1'b1, 1'b0, D_PX}};
			5'd1:  u = '{A_DZ,  B_E2Y, '{1'b1, 1'b0, 1'b1, D_PX}};
			5'd2:  u = '{A_DZ,  B_E2X, '{1'b0, 1'b1, 1'b0, D_PY}};
			5'd3:  u = '{A_DX,  B_E2Z, '{1'b1, 1'b0, 1'b1, D_PY}};
			5'd4:  u = '{A_DX,  B_E2Y, '{1'b0, 1'b1, 1'b0, D_PZ}};
			5'd5:  u = '{A_DY,  B_E2X, '{1'b1, 1'b0, 1'b1, D_PZ}};
			5'd6:  u = '{A_SY,  B_E1Z, '{1'b0, 1'b1, 1'b0, D_QX}};
			5'd7:  u = '{A_SZ,  B_E1Y, '{1'b1, 1'b0, 1'b1, D_QX}};
			5'd8:  u = '{A_SZ,  B_E1X, '{1'b0, 1'b1, 1'b0, D_QY}};
			5'd9:  u = '{A_SX,  B_E1Z, '{1'b1, 1'b0, 1'b1, D_QY}};
			5'd10: u = '{A_SX,  B_E1Y, '{1'b0, 1'b1, 1'b0, D_QZ}};
			5'd11: u = '{A_SY,  B_E1X, '{1'b1, 1'b0, 1'b1, D_QZ}};
			5'd12: u = '{A_E1X, B_PX,  '{1'b0, 1'b1, 1'b0, D_DET}};
			5'd13: u = '{A_E1Y, B_PY,  '{1'b0, 1'b0, 1'b0, D_DET}};
			5'd14: u = '{A_E1Z, B_PZ,  '{1'b0, 1'b0, 1'b1, D_DET}};
			5'd15: u = '{A_SX,  B_PX,  '{1'b0, 1'b1, 1'b0, D_UN}};
			5'd16: u = '{A_SY,  B_PY,  '{1'b0, 1'b0, 1'b0, D_UN}};
			5'd17: u = '{A_SZ,  B_PZ,  '{1'b0, 1'b0, 1'b1, D_UN}};
			5'd18: u = '{A_DX,  B_QX,  '{1'b0, 1'b1, 1'b0, D_VN}};
			5'd19: u = '{A_DY,  B_QY,  '{1'b0, 1'b0, 1'b0, D_VN}};
			5'd20: u = '{A_DZ,  B_QZ,  '{1'b0, 1'b0, 1'b1, D_VN}};
			5'd21: u = '{A_E2X, B_QX,  '{1'b0, 1'b1, 1'b0, D_TN}};
			5'd22: u = '{A_E2Y, B_QY,  '{1'b0, 1'b0, 1'b0, D_TN}};
			5'd23: u = '{A_E2Z, B_QZ,  '{1'b0, 1'b0, 1'b1, D_TN}};
			default: u = '{A_DX, B_E1X, '{1'b0, 1'b1, 1'b0, D_PX}};
		endcase
		return u;
	endfunction

endpackage

// File: src/rtch_ram.sv
module rtch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/rtch_mac.sv
module rtch_mac (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                issue,
	input  rtch_pkg::opa_t      a,
	input  rtch_pkg::opb_t      b,
	input  rtch_pkg::mac_ctl_t  ctl,
	output rtch_pkg::mac_res_t  res
);

	rtch_pkg::prod_t    prod_s1;
	rtch_pkg::mac_ctl_t ctl_s1;
	logic               vld_s1;
	rtch_pkg::acc_t     acc_q;
	rtch_pkg::acc_t     base;
	rtch_pkg::acc_t     sum;

	// Multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
		end
	end

	// full-width signed product
	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		ctl_s1  <= ctl;
	end

	// Accumulate stage
	always_comb begin
		base = ctl_s1.first ? '0 : acc_q;
		sum  = ctl_s1.sub ? base - rtch_pkg::acc_t'(prod_s1) : base + rtch_pkg::acc_t'(prod_s1);
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			acc_q <= sum;
		end
	end

	assign res.wr    = vld_s1 && ctl_s1.last;
	assign res.dest  = ctl_s1.dest;
	assign res.value = sum;

endmodule

// File: src/rtch_div.sv
module rtch_div (
	input  logic               clk,
	input  logic               arst_n,
	input  rtch_pkg::div_req_t req,
	output logic               done,
	output rtch_pkg::quo_t     quotient
);

	rtch_pkg::mag_t  rem_q;
	rtch_pkg::mag_t  den_q;
	rtch_pkg::quo_t  feed_q;
	rtch_pkg::quo_t  quo_q;
	rtch_pkg::step_t cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [56:0]     r2;
	logic [56:0]     diff;
	logic            ge;

	// One restoring step: shift in next dividend bit, trial subtract
	always_comb begin
		r2   = {rem_q, feed_q[23]};
		diff = r2 - {1'b0, den_q};
		ge   = (r2 >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.rem;
			den_q  <= req.den;
			feed_q <= req.feed;
			cnt_q  <= req.steps;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[55:0] : r2[55:0];
			feed_q <= {feed_q[22:0], 1'b0};
			quo_q  <= {quo_q[22:0], ge};
			cnt_q  <= cnt_q - 5'd1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: src/ray_triangle_closest_hit_unit.sv
// Closest-hit ray/triangle unit (Moller-Trumbore, exact fixed point).
// Input channel (in_valid/in_stall): mode 0 writes one triangle corner
// (slot, corner, pos_*, texture_id on corner 0) and gives no result;
// mode 1 casts a ray (pos_* origin, ray_dir_* Q1.14) and gives one result
// on the output channel (out_valid/out_stall).
// Config channel (cfg_valid/cfg_ready, always ready): index 0 triangle_count,
// index 1 det_min. Write only while the unit is idle.
// in_stall is high from ray acceptance until its result is loaded into the
// output register. Per tested triangle: corner reads, the program on the
// shared multiply-accumulate unit, checks and update, plus a t division in
// the shared divider when the triangle passes the tests unsaturated. After
// the walk, a hit adds two 17-step divisions for u and v, then the output
// is loaded. With no triangles the unit goes from accept straight to
// loading the output. If the output register is still stalled when a ray
// finishes, the unit holds and waits. Reset clears control state; the
// triangle tables are not cleared and every tested slot must be written
// first.
module ray_triangle_closest_hit_unit #(
	parameter int MAX_TRIANGLES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	// config
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	// input transactions
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [5:0]         slot,
	input  logic [1:0]         corner,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	input  logic signed [15:0] ray_dir_x,
	input  logic signed [15:0] ray_dir_y,
	input  logic signed [15:0] ray_dir_z,
	input  logic [5:0]         texture_id,
	// result transactions
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic [5:0]         hit_slot,
	output logic [5:0]         hit_texture,
	output logic [16:0]        bary_u,
	output logic [16:0]        bary_v,
	output logic [23:0]        hit_distance
);

	localparam int CDEPTH = 3 * MAX_TRIANGLES;
	localparam int CAW    = $clog2(CDEPTH);
	localparam int TAW    = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
	localparam int IW     = $clog2(MAX_TRIANGLES + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_MAC, S_NORM, S_TEST, S_TDIV, S_UPD, S_NEXT, S_UDIV, S_VDIV, S_FIN
	} state_t;

	state_t state_q;

	// Config registers
	logic [6:0]  tc_q;
	logic [31:0] det_min_q;

	// Ray and triangle registers
	logic signed [15:0] ox_q, oy_q, oz_q, dx_q, dy_q, dz_q;
	logic [47:0]        a_q, b_q, c_q;
	logic [IW-1:0]      n_q, idx_q;
	logic [CAW-1:0]     base_q;
	logic [1:0]         rd_cnt_q;
	logic [4:0]         uop_cnt_q;

	rtch_pkg::opb_t px_q, py_q, pz_q, qx_q, qy_q, qz_q;
	rtch_pkg::acc_t det_q, un_q, vn_q, tn_q;
	rtch_pkg::acc_t det_n_q, un_n_q, vn_n_q, tn_n_q;
	rtch_pkg::quo_t tq_q;

	// Best hit so far
	logic           found_q;
	rtch_pkg::quo_t best_t_q;
	rtch_pkg::acc_t best_un_q, best_vn_q, best_det_q;
	logic [IW-1:0]  best_slot_q;
	logic [5:0]     best_tex_q;
	logic [16:0]    u_q;

	// Output register
	logic        out_valid_q, hit_q;
	logic [5:0]  hit_slot_q, hit_tex_q;
	logic [16:0] bary_u_q, bary_v_q;
	logic [23:0] hit_dist_q;

	logic accept;
	logic corner_we, tex_we;
	logic [CAW-1:0] corner_waddr, corner_raddr;
	logic [47:0]    corner_rdata;
	logic           corner_re, tex_re;
	logic [5:0]     tex_rdata;
	logic [IW-1:0]  n_calc;

	rtch_pkg::opa_t e1x, e1y, e1z, e2x, e2y, e2z, sx, sy, sz;
	rtch_pkg::opa_t op_a;
	rtch_pkg::opb_t op_b;
	rtch_pkg::uop_t uop;
	logic           mac_issue;
	rtch_pkg::mac_res_t mac_res;

	logic           neg;
	logic           reject, t_sat, last_tri;
	rtch_pkg::div_req_t div_req;
	logic           div_done;
	rtch_pkg::quo_t div_quo;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// Table writes
	assign corner_we = accept && !mode && (corner < rtch_pkg::NUM_CORNERS)
		&& (32'(slot) < MAX_TRIANGLES);
	assign tex_we       = corner_we && (corner == 2'd0);
	assign corner_waddr = CAW'(32'(slot) * 3 + 32'(corner));
	assign corner_re    = (state_q == S_RD) && (rd_cnt_q != 2'd3);
	assign corner_raddr = base_q + CAW'(rd_cnt_q);
	assign tex_re       = (state_q == S_RD) && (rd_cnt_q == 2'd0);

	rtch_ram #(.WIDTH(48), .DEPTH(CDEPTH), .AW(CAW)) u_corner_ram (
		.clk   (clk),
		.we    (corner_we),
		.waddr (corner_waddr),
		.wdata ({pos_z, pos_y, pos_x}),
		.re    (corner_re),
		.raddr (corner_raddr),
		.rdata (corner_rdata)
	);

	rtch_ram #(.WIDTH(6), .DEPTH(MAX_TRIANGLES), .AW(TAW)) u_tex_ram (
		.clk   (clk),
		.we    (tex_we),
		.waddr (TAW'(slot)),
		.wdata (texture_id),
		.re    (tex_re),
		.raddr (TAW'(idx_q)),
		.rdata (tex_rdata)
	);

	assign n_calc = (32'(tc_q) > MAX_TRIANGLES) ? IW'(MAX_TRIANGLES) : IW'(tc_q);

	// Edge and origin vectors
	always_comb begin
		e1x = rtch_pkg::opa_t'($signed(b_q[15:0]))  - rtch_pkg::opa_t'($signed(a_q[15:0]));
		e1y = rtch_pkg::opa_t'($signed(b_q[31:16])) - rtch_pkg::opa_t'($signed(a_q[31:16]));
		e1z = rtch_pkg::opa_t'($signed(b_q[47:32])) - rtch_pkg::opa_t'($signed(a_q[47:32]));
		e2x = rtch_pkg::opa_t'($signed(c_q[15:0]))  - rtch_pkg::opa_t'($signed(a_q[15:0]));
		e2y = rtch_pkg::opa_t'($signed(c_q[31:16])) - rtch_pkg::opa_t'($signed(a_q[31:16]));
		e2z = rtch_pkg::opa_t'($signed(c_q[47:32])) - rtch_pkg::opa_t'($signed(a_q[47:32]));
		sx  = rtch_pkg::opa_t'(ox_q) - rtch_pkg::opa_t'($signed(a_q[15:0]));
		sy  = rtch_pkg::opa_t'(oy_q) - rtch_pkg::opa_t'($signed(a_q[31:16]));
		sz  = rtch_pkg::opa_t'(oz_q) - rtch_pkg::opa_t'($signed(a_q[47:32]));
	end

	// Operand selection for the shared multiplier
	assign uop       = rtch_pkg::uop_rom(uop_cnt_q);
	assign mac_issue = (state_q == S_MAC) && (uop_cnt_q != rtch_pkg::NUM_UOPS);

	always_comb begin
		unique case (uop.a)
			rtch_pkg::A_DX:  op_a = rtch_pkg::opa_t'(dx_q);
			rtch_pkg::A_DY:  op_a = rtch_pkg::opa_t'(dy_q);
			rtch_pkg::A_DZ:  op_a = rtch_pkg::opa_t'(dz_q);
			rtch_pkg::A_E1X: op_a = e1x;
			rtch_pkg::A_E1Y: op_a = e1y;
			rtch_pkg::A_E1Z: op_a = e1z;
			rtch_pkg::A_E2X: op_a = e2x;
			rtch_pkg::A_E2Y: op_a = e2y;
			rtch_pkg::A_E2Z: op_a = e2z;
			rtch_pkg::A_SX:  op_a = sx;
			rtch_pkg::A_SY:  op_a = sy;
			rtch_pkg::A_SZ:  op_a = sz;
			default:         op_a = '0;
		endcase
		unique case (uop.b)
			rtch_pkg::B_E1X: op_b = rtch_pkg::opb_t'(e1x);
			rtch_pkg::B_E1Y: op_b = rtch_pkg::opb_t'(e1y);
			rtch_pkg::B_E1Z: op_b = rtch_pkg::opb_t'(e1z);
			rtch_pkg::B_E2X: op_b = rtch_pkg::opb_t'(e2x);
			rtch_pkg::B_E2Y: op_b = rtch_pkg::opb_t'(e2y);
			rtch_pkg::B_E2Z: op_b = rtch_pkg::opb_t'(e2z);
			rtch_pkg::B_PX:  op_b = px_q;
			rtch_pkg::B_PY:  op_b = py_q;
			rtch_pkg::B_PZ:  op_b = pz_q;
			rtch_pkg::B_QX:  op_b = qx_q;
			rtch_pkg::B_QY:  op_b = qy_q;
			rtch_pkg::B_QZ:  op_b = qz_q;
			default:         op_b = '0;
		endcase
	end

	rtch_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (mac_issue),
		.a      (op_a),
		.b      (op_b),
		.ctl    (uop.ctl),
		.res    (mac_res)
	);

	// Acceptance tests on the sign-normalized values
	assign neg = det_q[55];
	always_comb begin
		reject = (det_n_q == '0)
			|| (rtch_pkg::mag_t'(det_n_q) < rtch_pkg::mag_t'(det_min_q))
			|| (un_n_q < 0) || (un_n_q > det_n_q)
			|| (vn_n_q < 0) || ((un_n_q + vn_n_q) > det_n_q)
			|| (tn_n_q < 0);
		t_sat    = (tn_n_q >= (det_n_q <<< 2));
		last_tri = ((idx_q + IW'(1)) == n_q);
	end

	// Divider requests: t per passing, unsaturated triangle, u and v once at the end
	always_comb begin
		div_req = '0;
		if ((state_q == S_TEST) && !reject && !t_sat) begin
			div_req.start = 1'b1;
			div_req.rem   = rtch_pkg::mag_t'(tn_n_q >>> 2);
			div_req.feed  = {tn_n_q[1:0], 22'b0};
			div_req.steps = rtch_pkg::T_STEPS;
			div_req.den   = rtch_pkg::mag_t'(det_n_q);
		end else if ((state_q == S_NEXT) && last_tri && found_q) begin
			div_req.start = 1'b1;
			div_req.rem   = rtch_pkg::mag_t'(best_un_q >>> 1);
			div_req.feed  = {best_un_q[0], 23'b0};
			div_req.steps = rtch_pkg::UV_STEPS;
			div_req.den   = rtch_pkg::mag_t'(best_det_q);
		end else if ((state_q == S_UDIV) && div_done) begin
			div_req.start = 1'b1;
			div_req.rem   = rtch_pkg::mag_t'(best_vn_q >>> 1);
			div_req.feed  = {best_vn_q[0], 23'b0};
			div_req.steps = rtch_pkg::UV_STEPS;
			div_req.den   = rtch_pkg::mag_t'(best_det_q);
		end
	end

	rtch_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q      <= '0;
			det_min_q <= 32'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rtch_pkg::CFG_TRI_COUNT: tc_q      <= cfg_data[6:0];
				rtch_pkg::CFG_DET_MIN:   det_min_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			idx_q       <= '0;
			n_q         <= '0;
			base_q      <= '0;
			rd_cnt_q    <= '0;
			uop_cnt_q   <= '0;
		end else begin
			// S_FIN reloads the output register itself
			if (out_valid_q && !out_stall && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && mode) begin
						n_q      <= n_calc;
						idx_q    <= '0;
						base_q   <= '0;
						rd_cnt_q <= '0;
						found_q  <= 1'b0;
						state_q  <= (n_calc == '0) ? S_FIN : S_RD;
					end
				end
				S_RD: begin
					rd_cnt_q <= rd_cnt_q + 2'd1;
					if (rd_cnt_q == 2'd3) begin
						uop_cnt_q <= '0;
						state_q   <= S_MAC;
					end
				end
				S_MAC: begin
					uop_cnt_q <= uop_cnt_q + 5'd1;
					if (uop_cnt_q == rtch_pkg::NUM_UOPS) begin
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					state_q <= S_TEST;
				end
				S_TEST: begin
					if (reject) begin
						state_q <= S_NEXT;
					end else if (t_sat) begin
						state_q <= S_UPD;
					end else begin
						state_q <= S_TDIV;
					end
				end
				S_TDIV: begin
					if (div_done) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (!(found_q && (tq_q > best_t_q))) begin
						found_q <= 1'b1;
					end
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (last_tri) begin
						state_q <= found_q ? S_UDIV : S_FIN;
					end else begin
						idx_q    <= idx_q + IW'(1);
						base_q   <= base_q + CAW'(3);
						rd_cnt_q <= '0;
						state_q  <= S_RD;
					end
				end
				S_UDIV: begin
					if (div_done) begin
						state_q <= S_VDIV;
					end
				end
				S_VDIV: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept && mode) begin
			ox_q <= pos_x;
			oy_q <= pos_y;
			oz_q <= pos_z;
			dx_q <= ray_dir_x;
			dy_q <= ray_dir_y;
			dz_q <= ray_dir_z;
		end
		// corner data is captured in the cycle after its read
		if (state_q == S_RD) begin
			case (rd_cnt_q)
				2'd1:    a_q <= corner_rdata;
				2'd2:    b_q <= corner_rdata;
				2'd3:    c_q <= corner_rdata;
				default: ;
			endcase
		end
		if (mac_res.wr) begin
			unique case (mac_res.dest)
				rtch_pkg::D_PX:  px_q  <= rtch_pkg::opb_t'(mac_res.value);
				rtch_pkg::D_PY:  py_q  <= rtch_pkg::opb_t'(mac_res.value);
				rtch_pkg::D_PZ:  pz_q  <= rtch_pkg::opb_t'(mac_res.value);
				rtch_pkg::D_QX:  qx_q  <= rtch_pkg::opb_t'(mac_res.value);
				rtch_pkg::D_QY:  qy_q  <= rtch_pkg::opb_t'(mac_res.value);
				rtch_pkg::D_QZ:  qz_q  <= rtch_pkg::opb_t'(mac_res.value);
				rtch_pkg::D_DET: det_q <= mac_res.value;
				rtch_pkg::D_UN:  un_q  <= mac_res.value;
				rtch_pkg::D_VN:  vn_q  <= mac_res.value;
				rtch_pkg::D_TN:  tn_q  <= mac_res.value;
				default: ;
			endcase
		end
		// flip signs so that det is non-negative
		if (state_q == S_NORM) begin
			det_n_q <= neg ? -det_q : det_q;
			un_n_q  <= neg ? -un_q  : un_q;
			vn_n_q  <= neg ? -vn_q  : vn_q;
			tn_n_q  <= neg ? -tn_q  : tn_q;
		end
		if ((state_q == S_TEST) && t_sat) begin
			tq_q <= rtch_pkg::T_SAT;
		end else if ((state_q == S_TDIV) && div_done) begin
			tq_q <= div_quo;
		end
		// closer or equal distance replaces the best hit
		if ((state_q == S_UPD) && !(found_q && (tq_q > best_t_q))) begin
			best_t_q    <= tq_q;
			best_un_q   <= un_n_q;
			best_vn_q   <= vn_n_q;
			best_det_q  <= det_n_q;
			best_slot_q <= idx_q;
			best_tex_q  <= tex_rdata;
		end
		if ((state_q == S_UDIV) && div_done) begin
			u_q <= div_quo[16:0];
		end
		if ((state_q == S_FIN) && (!out_valid_q || !out_stall)) begin
			hit_q      <= found_q;
			hit_slot_q <= found_q ? 6'(best_slot_q) : 6'd0;
			hit_tex_q  <= found_q ? best_tex_q : 6'd0;
			bary_u_q   <= found_q ? u_q : 17'd0;
			bary_v_q   <= found_q ? div_quo[16:0] : 17'd0;
			hit_dist_q <= found_q ? best_t_q : 24'd0;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign hit_slot     = hit_slot_q;
	assign hit_texture  = hit_tex_q;
	assign bary_u       = bary_u_q;
	assign bary_v       = bary_v_q;
	assign hit_distance = hit_dist_q;

endmodule
